[design/tab_expander_with_trim_core_assert.svh]
// Assertion macros used by the tab expander RTL.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef TAB_EXPANDER_WITH_TRIM_CORE_ASSERT_SVH
`define TAB_EXPANDER_WITH_TRIM_CORE_ASSERT_SVH

// Same-cycle property, disabled while reset is asserted.
`define TEWT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define TEWT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tabexp_pkg.sv]
// Package for the tab expander: field widths, character codes and register indexes.
// No dependencies.
package tabexp_pkg;

  localparam int MAX_BUFFER_DEF = 64;

  localparam int CHAR_W = 8;
  localparam int TW_W   = 8;
  localparam int BS_W   = 7;
  localparam int LEN_W  = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_TAB_WIDTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE = 1'b1;

  localparam logic [TW_W-1:0] TAB_WIDTH_DEFAULT = 8'd8;
  localparam logic [BS_W-1:0] BUFFER_SIZE_RESET = 7'd64;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  // Pending store entry codes.
  localparam logic KIND_SPACE   = 1'b0;
  localparam logic KIND_NEWLINE = 1'b1;

endpackage

[design/tabexp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tabexp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[design/tab_expander_with_trim_core.sv]
// Tab expander with trailing-whitespace trim. Uses tabexp_pkg and tabexp_ram.
// Accepts one source word at a time. A tab finds out_index mod tab_width by repeated
// subtraction in one subtractor and then adds its spaces; a placed byte first replays the
// pending whitespace; closing whitespace or a closing dropped byte adds an end marker.
// Reset (rst_n low, synchronous) clears string state, stop flag and output valid; config registers take their defaults.
`include "tab_expander_with_trim_core_assert.svh"

module tab_expander_with_trim_core #(
  parameter int MAX_BUFFER = tabexp_pkg::MAX_BUFFER_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel: one source byte per word.
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tabexp_pkg::CHAR_W-1:0]  in_char_in,
  input  logic                           in_last_in,
  // Result channel.
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tabexp_pkg::CHAR_W-1:0]  out_char_out,
  output logic                           out_char_valid,
  output logic                           out_last_out,
  output logic [tabexp_pkg::LEN_W-1:0]   out_trimmed_length,
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [tabexp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tabexp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import tabexp_pkg::*;

  // Index width: out_index never exceeds MAX_BUFFER-1, so this many bits suffice.
  localparam int IDX_W = $clog2(MAX_BUFFER);

  // The sequencer. IDLE takes a word; whitespace is stored right there.
  // MOD finds out_index mod tab_width by repeated subtraction, TAB then
  // appends spaces one per cycle. FL_RD/FL_OUT replay the pending run from
  // the store, CHAR_OUT sends the placed byte and END_OUT a bare end marker.
  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_MOD      = 7'b0000010,
    S_TAB      = 7'b0000100,
    S_FL_RD    = 7'b0001000,
    S_FL_OUT   = 7'b0010000,
    S_CHAR_OUT = 7'b0100000,
    S_END_OUT  = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [TW_W-1:0]   tab_width_r, tab_width_nxt;
  logic [BS_W-1:0]   buffer_size_r, buffer_size_nxt;
  logic [IDX_W-1:0]  out_index_r, out_index_nxt;
  logic [IDX_W-1:0]  pending_count_r, pending_count_nxt;
  logic [IDX_W-1:0]  emitted_count_r, emitted_count_nxt;
  logic              stopped_r, stopped_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              last_r, last_nxt;
  logic [TW_W-1:0]   rem_r, rem_nxt;
  logic [IDX_W-1:0]  flush_idx_r, flush_idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_cvalid_r, out_cvalid_nxt;
  logic              out_last_r, out_last_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;

  logic              mem_we;
  logic              mem_wdata;
  logic              mem_rdata;

  logic              in_fire;
  logic              slot_free;
  logic [TW_W-1:0]   tw_eff;
  logic [BS_W-1:0]   cap;
  logic [BS_W-1:0]   limit_wide;
  logic [IDX_W-1:0]  limit;
  logic              room;
  logic [IDX_W-1:0]  emitted_inc;
  logic [IDX_W-1:0]  flush_inc;

  // A tab width of zero means the default stop spacing of eight.
  assign tw_eff = (tab_width_r == '0) ? TAB_WIDTH_DEFAULT : tab_width_r;

  // Output limit is one less than the buffer size, after saturating at MAX_BUFFER.
  assign cap        = (buffer_size_r > BS_W'(MAX_BUFFER)) ? BS_W'(MAX_BUFFER) : buffer_size_r;
  assign limit_wide = (cap == '0) ? '0 : cap - BS_W'(1);
  assign limit      = limit_wide[IDX_W-1:0];
  assign room       = (out_index_r < limit);

  assign emitted_inc = emitted_count_r + IDX_W'(1);
  assign flush_inc   = flush_idx_r + IDX_W'(1);

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // Pending whitespace store: one bit per entry, space or newline.
  tabexp_ram #(
    .WIDTH (1),
    .DEPTH (MAX_BUFFER)
  ) u_pending (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (pending_count_r),
    .wr_data (mem_wdata),
    .rd_addr (flush_idx_r),
    .rd_data (mem_rdata)
  );

  always_comb begin
    state_nxt         = state_r;
    tab_width_nxt     = tab_width_r;
    buffer_size_nxt   = buffer_size_r;
    out_index_nxt     = out_index_r;
    pending_count_nxt = pending_count_r;
    emitted_count_nxt = emitted_count_r;
    stopped_nxt       = stopped_r;
    char_nxt          = char_r;
    last_nxt          = last_r;
    rem_nxt           = rem_r;
    flush_idx_nxt     = flush_idx_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_char_nxt      = out_char_r;
    out_cvalid_nxt    = out_cvalid_r;
    out_last_nxt      = out_last_r;
    out_len_nxt       = out_len_r;
    mem_we            = 1'b0;
    mem_wdata         = KIND_SPACE;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_TAB_WIDTH:   tab_width_nxt   = cfg_wdata[TW_W-1:0];
        CFG_BUFFER_SIZE: buffer_size_nxt = cfg_wdata[BS_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          char_nxt = in_char_in;
          last_nxt = in_last_in;
          if (stopped_r) begin
            // Words after a NUL are ignored until the one that ends the source string.
            if (in_last_in) begin
              stopped_nxt       = 1'b0;
              out_index_nxt     = '0;
              pending_count_nxt = '0;
              emitted_count_nxt = '0;
            end
          end else if (in_char_in == CHAR_NUL) begin
            state_nxt = S_END_OUT;
          end else if (in_char_in == CHAR_TAB) begin
            rem_nxt   = TW_W'(out_index_r);
            state_nxt = S_MOD;
          end else if (in_char_in == CHAR_SPACE || in_char_in == CHAR_NL) begin
            if (room) begin
              mem_we            = 1'b1;
              mem_wdata         = (in_char_in == CHAR_NL) ? KIND_NEWLINE : KIND_SPACE;
              pending_count_nxt = pending_count_r + IDX_W'(1);
              out_index_nxt     = out_index_r + IDX_W'(1);
            end
            if (in_last_in) begin
              state_nxt = S_END_OUT;
            end
          end else if (room) begin
            flush_idx_nxt = '0;
            state_nxt     = (pending_count_r != '0) ? S_FL_RD : S_CHAR_OUT;
          end else if (in_last_in) begin
            // Byte past the limit is dropped; the string still needs its end marker.
            state_nxt = S_END_OUT;
          end
        end
      end

      S_MOD: begin
        if (rem_r >= tw_eff) begin
          rem_nxt = rem_r - tw_eff;
        end else begin
          state_nxt = S_TAB;
        end
      end

      S_TAB: begin
        // rem_r walks up to the next stop; the limit cuts the run short.
        if (room && rem_r != tw_eff) begin
          mem_we            = 1'b1;
          mem_wdata         = KIND_SPACE;
          pending_count_nxt = pending_count_r + IDX_W'(1);
          out_index_nxt     = out_index_r + IDX_W'(1);
          rem_nxt           = rem_r + TW_W'(1);
        end else begin
          state_nxt = last_r ? S_END_OUT : S_IDLE;
        end
      end

      S_FL_RD: begin
        // Read data for flush_idx_r shows up in the next cycle.
        state_nxt = S_FL_OUT;
      end

      S_FL_OUT: begin
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          out_char_nxt      = (mem_rdata == KIND_NEWLINE) ? CHAR_NL : CHAR_SPACE;
          out_cvalid_nxt    = 1'b1;
          out_last_nxt      = 1'b0;
          out_len_nxt       = '0;
          emitted_count_nxt = emitted_inc;
          flush_idx_nxt     = flush_inc;
          state_nxt         = (flush_inc == pending_count_r) ? S_CHAR_OUT : S_FL_RD;
        end
      end

      S_CHAR_OUT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_char_nxt   = char_r;
          out_cvalid_nxt = 1'b1;
          out_last_nxt   = last_r;
          out_len_nxt    = last_r ? LEN_W'(emitted_inc) : '0;
          if (last_r) begin
            out_index_nxt     = '0;
            pending_count_nxt = '0;
            emitted_count_nxt = '0;
          end else begin
            out_index_nxt     = out_index_r + IDX_W'(1);
            pending_count_nxt = '0;
            emitted_count_nxt = emitted_inc;
          end
          state_nxt = S_IDLE;
        end
      end

      S_END_OUT: begin
        // Bare end marker; pending whitespace is trimmed away.
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          out_char_nxt      = CHAR_NUL;
          out_cvalid_nxt    = 1'b0;
          out_last_nxt      = 1'b1;
          out_len_nxt       = LEN_W'(emitted_count_r);
          out_index_nxt     = '0;
          pending_count_nxt = '0;
          emitted_count_nxt = '0;
          stopped_nxt       = (char_r == CHAR_NUL) && !last_r;
          state_nxt         = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      tab_width_r     <= TAB_WIDTH_DEFAULT;
      buffer_size_r   <= BUFFER_SIZE_RESET;
      out_index_r     <= '0;
      pending_count_r <= '0;
      emitted_count_r <= '0;
      stopped_r       <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      tab_width_r     <= tab_width_nxt;
      buffer_size_r   <= buffer_size_nxt;
      out_index_r     <= out_index_nxt;
      pending_count_r <= pending_count_nxt;
      emitted_count_r <= emitted_count_nxt;
      stopped_r       <= stopped_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r       <= char_nxt;
    last_r       <= last_nxt;
    rem_r        <= rem_nxt;
    flush_idx_r  <= flush_idx_nxt;
    out_char_r   <= out_char_nxt;
    out_cvalid_r <= out_cvalid_nxt;
    out_last_r   <= out_last_nxt;
    out_len_r    <= out_len_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_char_out       = out_char_r;
  assign out_char_valid     = out_cvalid_r;
  assign out_last_out       = out_last_r;
  assign out_trimmed_length = out_len_r;

  // Every pending entry occupies one output column.
  `TEWT_ASSERT(a_pending_le_index, pending_count_r <= out_index_r,
               "pending count exceeds output index")
  // The tab remainder never passes the stop spacing.
  `TEWT_ASSERT(a_tab_rem_bound, (state_r == S_TAB) |-> (rem_r <= tw_eff),
               "tab remainder beyond tab width")
  // Replay only reads entries that were written for this string.
  `TEWT_ASSERT(a_flush_in_range,
               (state_r == S_FL_RD || state_r == S_FL_OUT) |-> (flush_idx_r < pending_count_r),
               "flush index outside pending run")
  // The length field is only nonzero on the final word of a string.
  `TEWT_ASSERT(a_len_only_last, (out_valid_r && !out_last_r) |-> (out_len_r == '0),
               "trimmed length on a non-final word")
  // A closing word while stopped restarts a clean string.
  `TEWT_ASSERT_NEXT(a_stop_release, in_fire && stopped_r && in_last_in,
                    !stopped_r && out_index_r == '0 && pending_count_r == '0,
                    "stop not released by final word")

endmodule

[bench/tab_expander_with_trim_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the tab expander: watches the input, result and configuration ports,
// predicts every result word from accepted source bytes and compares. Uses tabexp_pkg.
module tab_expander_with_trim_checker #(
  parameter int MAX_BUFFER = tabexp_pkg::MAX_BUFFER_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [tabexp_pkg::CHAR_W-1:0]     in_char_in,
  input  logic                              in_last_in,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [tabexp_pkg::CHAR_W-1:0]     out_char_out,
  input  logic                              out_char_valid,
  input  logic                              out_last_out,
  input  logic [tabexp_pkg::LEN_W-1:0]      out_trimmed_length,
  input  logic                              cfg_we,
  input  logic [tabexp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tabexp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                                fail_count,
  output int                                waiting_words,
  output int                                checked_words,
  output int                                closed_strings
);
  import tabexp_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              vld;
    logic              lst;
    logic [LEN_W-1:0]  len;
  } text_word_t;

  text_word_t        expected_words[$];
  logic [TW_W-1:0]   tab_stop;
  logic [BS_W-1:0]   buf_size;
  logic              ws_kind[MAX_BUFFER];
  int                col;
  int                ws_count;
  int                emitted;
  bit                halted;
  int                errors;
  int                checked;
  int                closed;

  function automatic void push_word(logic [CHAR_W-1:0] ch, logic vld, logic lst, int len);
    text_word_t w;
    w.ch  = ch;
    w.vld = vld;
    w.lst = lst;
    w.len = lst ? LEN_W'(len) : '0;
    expected_words.push_back(w);
    if (lst) closed++;
  endfunction

  function automatic void clear_line();
    col      = 0;
    ws_count = 0;
    emitted  = 0;
  endfunction

  function automatic void add_ws(logic kind, int limit);
    if (col < limit && ws_count < MAX_BUFFER) begin
      ws_kind[ws_count] = kind;
      ws_count++;
      col++;
    end
  endfunction

  // Works out every result word caused by one accepted source byte.
  function automatic void expand_word(logic [CHAR_W-1:0] c, logic l);
    int limit;
    int tw;
    int spaces;
    bit placed;
    limit  = (buf_size > MAX_BUFFER) ? MAX_BUFFER : int'(buf_size);
    limit  = (limit > 0) ? limit - 1 : 0;
    tw     = (tab_stop == 0) ? 8 : int'(tab_stop);
    placed = 0;
    if (halted) begin
      if (l) begin
        halted = 0;
        clear_line();
      end
      return;
    end
    if (c == CHAR_NUL) begin
      push_word(CHAR_NUL, 1'b0, 1'b1, emitted);
      clear_line();
      if (!l) halted = 1;
      return;
    end
    if (c == CHAR_TAB) begin
      spaces = tw - (col % tw);
      for (int i = 0; i < spaces && col < limit; i++) add_ws(KIND_SPACE, limit);
    end else if (c == CHAR_SPACE) begin
      add_ws(KIND_SPACE, limit);
    end else if (c == CHAR_NL) begin
      add_ws(KIND_NEWLINE, limit);
    end else if (col < limit) begin
      for (int i = 0; i < ws_count; i++)
        push_word((ws_kind[i] == KIND_NEWLINE) ? CHAR_NL : CHAR_SPACE, 1'b1, 1'b0, 0);
      emitted += ws_count;
      ws_count = 0;
      col++;
      emitted++;
      push_word(c, 1'b1, l, emitted);
      placed = 1;
    end
    if (l) begin
      if (!placed) push_word(CHAR_NUL, 1'b0, 1'b1, emitted);
      clear_line();
    end
  endfunction

  always @(posedge clk) begin
    text_word_t got;
    text_word_t want;
    if (!rst_n) begin
      expected_words.delete();
      tab_stop = TAB_WIDTH_DEFAULT;
      buf_size = BUFFER_SIZE_RESET;
      halted   = 0;
      clear_line();
      errors   = 0;
      checked  = 0;
      closed   = 0;
    end else begin
      // A register write lands before any byte accepted later.
      if (cfg_we) begin
        case (cfg_index)
          CFG_TAB_WIDTH:   tab_stop = cfg_wdata[TW_W-1:0];
          CFG_BUFFER_SIZE: buf_size = cfg_wdata[BS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expand_word(in_char_in, in_last_in);
      if (out_valid && out_ready) begin
        got = {out_char_out, out_char_valid, out_last_out, out_trimmed_length};
        checked++;
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result word ch=%02h valid=%0b last=%0b len=%0d",
                     $realtime, got.ch, got.vld, got.lst, got.len);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: result mismatch: expected ch=%02h valid=%0b last=%0b len=%0d,",
                        " got ch=%02h valid=%0b last=%0b len=%0d"},
                       $realtime, want.ch, want.vld, want.lst, want.len,
                       got.ch, got.vld, got.lst, got.len);
          end
        end
      end
    end
    fail_count     <= errors;
    waiting_words  <= expected_words.size();
    checked_words  <= checked;
    closed_strings <= closed;
  end

endmodule

[bench/tab_expander_with_trim_core_test.sv]
`timescale 1ns / 1ps
// Top of the tab expander bench: clock, reset, stimulus, configuration phases and verdict.
// Depends on tabexp_pkg, tab_expander_with_trim_core and tab_expander_with_trim_checker.
module tab_expander_with_trim_core_test;
  import tabexp_pkg::*;

  // Long enough for the slowest tab expansion (tab width one near the end of a full
  // buffer) plus the longest receiver stall, taken several times over.
  localparam int STALL_LIMIT   = 4000;
  // Idle time after the last expected word before a register write or the verdict.
  // A whitespace byte makes no result but may keep the block busy for a while.
  localparam int SETTLE_CYCLES = 160;
  localparam int PHASES        = 11;
  localparam int PHASE_WORDS   = 20;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [CHAR_W-1:0]     in_char_in  = '0;
  logic                  in_last_in  = 1'b0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [CHAR_W-1:0]     out_char_out;
  logic                  out_char_valid;
  logic                  out_last_out;
  logic [LEN_W-1:0]      out_trimmed_length;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = CFG_TAB_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;

  int fail_count;
  int waiting_words;
  int checked_words;
  int closed_strings;

  // When set, both sides run flat out with no gaps.
  bit quiet       = 0;
  int sent_words  = 0;
  int settings    = 0;
  int stall_cycles = 0;
  int ready_hold  = 0;

  tab_expander_with_trim_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_char_in         (in_char_in),
    .in_last_in         (in_last_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_char_out       (out_char_out),
    .out_char_valid     (out_char_valid),
    .out_last_out       (out_last_out),
    .out_trimmed_length (out_trimmed_length),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  tab_expander_with_trim_checker text_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_char_in         (in_char_in),
    .in_last_in         (in_last_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_char_out       (out_char_out),
    .out_char_valid     (out_char_valid),
    .out_last_out       (out_last_out),
    .out_trimmed_length (out_trimmed_length),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .fail_count         (fail_count),
    .waiting_words      (waiting_words),
    .checked_words      (checked_words),
    .closed_strings     (closed_strings)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Number of idle cycles before the next word on either side.
  function automatic int idle_gap();
    if (quiet) return 0;
    return $urandom_range(0, 13);
  endfunction

  // Receiver: after each accepted result word it may hold ready low for a drawn number
  // of cycles. While nothing is offered ready goes back high, so the next word from the
  // block meets either an open receiver or the tail of a drawn stall.
  always @(posedge clk) begin
    int n;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      out_ready  <= (ready_hold == 1);
    end else if (out_valid && out_ready) begin
      n = idle_gap();
      if (n == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        ready_hold <= n;
      end
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: any cycle with a handshake on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Watchdog expired: no word moved for %0d cycles", STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offers one source byte and returns at the edge where it is accepted. Valid is only
  // lowered when a gap is drawn, so back-to-back words keep it high throughout.
  task automatic send_word(input logic [CHAR_W-1:0] c, input logic l);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_char_in <= c;
    in_last_in <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_words++;
  endtask

  // Stops sending and waits until every predicted result word has been taken, then
  // lets the given number of extra cycles pass.
  task automatic drain(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting_words != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Writes both registers while the block is idle.
  task automatic write_config(input logic [TW_W-1:0] tw, input logic [BS_W-1:0] bs);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TAB_WIDTH;
    cfg_wdata <= CFG_DATA_W'(tw);
    @(posedge clk);
    cfg_index <= CFG_BUFFER_SIZE;
    cfg_wdata <= CFG_DATA_W'(bs);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  // Source bytes weighted toward text with plenty of whitespace, an occasional NUL,
  // and a share of arbitrary bytes so every bit of the field toggles.
  function automatic logic [CHAR_W-1:0] rand_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) return CHAR_W'($urandom_range(33, 126));
    if (pick < 50) return CHAR_SPACE;
    if (pick < 62) return CHAR_TAB;
    if (pick < 72) return CHAR_NL;
    if (pick < 76) return CHAR_NUL;
    return CHAR_W'($urandom_range(1, 255));
  endfunction

  // One string ended by last_in. Most are short; a few run well past the buffer limit
  // so that dropping is exercised.
  task automatic send_string();
    int len;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7)      len = $urandom_range(1, 12);
    else if (pick < 9) len = $urandom_range(13, 40);
    else               len = $urandom_range(41, 80);
    for (int i = 0; i < len; i++) send_word(rand_char(), i == len - 1);
  endtask

  initial begin
    logic [TW_W-1:0] tw;
    logic [BS_W-1:0] bs;
    int phase_start;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings at the reset settings (tab width 8, buffer 64).
    // Pending whitespace, a tab at a mid column, extreme byte values, then a final
    // non-whitespace byte that flushes the run and closes the string.
    send_word(8'h41, 1'b0);
    send_word(CHAR_TAB, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(CHAR_SPACE, 1'b0);
    send_word(CHAR_NL, 1'b0);
    send_word(8'h01, 1'b1);
    // Trailing whitespace is cut; the string closes with a bare end marker.
    send_word(8'h78, 1'b0);
    send_word(CHAR_SPACE, 1'b0);
    send_word(CHAR_TAB, 1'b0);
    send_word(CHAR_NL, 1'b1);
    // NUL without last discards the pending run and stops the block; the bytes after
    // it are ignored until one carries last, which only restarts the string.
    send_word(CHAR_TAB, 1'b0);
    send_word(CHAR_NUL, 1'b0);
    send_word(8'h71, 1'b0);
    send_word(CHAR_NUL, 1'b0);
    send_word(8'h72, 1'b1);
    // NUL carrying last ends the string without stopping.
    send_word(8'h7A, 1'b0);
    send_word(CHAR_NUL, 1'b1);
    // Short strings: a lone DEL byte, whitespace only, a byte closed by NUL, and a bare NUL.
    send_word(8'h7F, 1'b1);
    send_word(CHAR_SPACE, 1'b1);
    send_word(8'h80, 1'b0);
    send_word(CHAR_NUL, 1'b1);
    send_word(CHAR_NUL, 1'b1);

    // Random phases. The first ones pin the register extremes: tab width 0 (default),
    // 1 and 255, buffer size 0 (everything dropped), 1, 2 and values past the maximum.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin tw = 8'd0;   bs = 7'd64;  end
        1:       begin tw = 8'd1;   bs = 7'd127; end
        2:       begin tw = 8'd255; bs = 7'd2;   end
        3:       begin tw = 8'd3;   bs = 7'd0;   end
        4:       begin tw = 8'd1;   bs = 7'd1;   end
        5:       begin tw = 8'd2;   bs = 7'd64;  end
        6:       begin tw = 8'd8;   bs = 7'd100; end
        default: begin
          tw = ($urandom_range(0, 1) == 0) ? TW_W'($urandom_range(1, 12))
                                           : TW_W'($urandom_range(0, 255));
          bs = ($urandom_range(0, 1) == 0) ? BS_W'($urandom_range(1, 64))
                                           : BS_W'($urandom_range(0, 127));
        end
      endcase
      // Registers change only with nothing in flight and the block settled.
      drain(SETTLE_CYCLES);
      write_config(tw, bs);
      quiet = ($urandom_range(0, 3) == 0);
      phase_start = sent_words;
      while (sent_words - phase_start < PHASE_WORDS) begin
        send_string();
        // Now and then the sender holds off until the result side is empty.
        if ($urandom_range(0, 7) == 0) drain(0);
      end
    end

    drain(SETTLE_CYCLES);
    $display("Sent %0d source words under %0d register settings; checked %0d result words",
             sent_words, settings, checked_words);
    $display("closing %0d strings, with %0d mismatches.", closed_strings, fail_count);
    if (fail_count == 0 && waiting_words == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
